>>> hw/rtl/rcas_pkg.sv
// shared types and constants for the region concatenation address splitter
`default_nettype none
package rcas_pkg;

   localparam int NUM_REGIONS_DEF     = 3;
   localparam int SECTOR_BYTES_DEF    = 65536;
   localparam int SUBSECTOR_BYTES_DEF = 4096;
   localparam int ADDR_BITS_DEF       = 24;

   localparam int MAX_REGIONS = 3;
   localparam int OFFSET_W    = 24;
   localparam int BYTES_W     = 25;
   localparam int VIRT_W      = 27;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int TDATA_W     = 56;

   typedef enum logic [1:0] {
      OP_READ            = 2'd0,
      OP_WRITE           = 2'd1,
      OP_SECTOR_ERASE    = 2'd2,
      OP_SUBSECTOR_ERASE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_ERASE_SIZE = 2'd1,
      STATUS_BEYOND     = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CSR_REGION0_START  = 3'd0,
      CSR_REGION0_END    = 3'd1,
      CSR_REGION1_START  = 3'd2,
      CSR_REGION1_END    = 3'd3,
      CSR_REGION2_START  = 3'd4,
      CSR_REGION2_END    = 3'd5,
      CSR_ACTIVE_REGIONS = 3'd6
   } csr_index_type;

endpackage
`default_nettype wire

>>> hw/rtl/region_concat_address_splitter.sv
// top level: splits a virtual flash request into one command per region it touches
//
// A request of 1 transaction yields 1 to 3 result transactions, one per cycle while the
// output is not stalled by rsp_tready, from a single output register. The request sits
// in an input register while its results are produced; the next request is taken in
// the same cycle that the last result of the current one is loaded into the output
// register. Region registers are read live, so they must be written only while idle;
// the block itself does not enforce this.
`default_nettype none
module region_concat_address_splitter #(
   parameter int NUM_REGIONS     = rcas_pkg::NUM_REGIONS_DEF,
   parameter int SECTOR_BYTES    = rcas_pkg::SECTOR_BYTES_DEF,
   parameter int SUBSECTOR_BYTES = rcas_pkg::SUBSECTOR_BYTES_DEF,
   parameter int ADDR_BITS       = rcas_pkg::ADDR_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rcas_pkg::TDATA_W-1:0]      req_tdata,   // virt_offset, req_bytes
   input  logic [1:0]                        req_tuser,   // req_type
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rcas_pkg::TDATA_W-1:0]      rsp_tdata,   // flash_addr, chunk_bytes
   output logic [3:0]                        rsp_tuser,   // flash_op, status
   output logic                              rsp_tlast,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rcas_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [rcas_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [rcas_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import rcas_pkg::*;

   localparam logic [1:0] NumRegions = 2'(NUM_REGIONS);
   localparam logic [BYTES_W-1:0] SectorBytes = BYTES_W'(SECTOR_BYTES);
   localparam logic [BYTES_W-1:0] SubsectorBytes = BYTES_W'(SUBSECTOR_BYTES);
   localparam logic [OFFSET_W-1:0] AddrMask = (ADDR_BITS >= OFFSET_W) ?
      {OFFSET_W{1'b1}} : OFFSET_W'((64'd1 << ADDR_BITS) - 64'd1);

   // configuration
   logic [BYTES_W-1:0]  region_start_ff [MAX_REGIONS];
   logic [BYTES_W-1:0]  region_end_ff   [MAX_REGIONS];
   logic [BYTES_W-1:0]  region_start_in [MAX_REGIONS];
   logic [BYTES_W-1:0]  region_end_in   [MAX_REGIONS];
   logic [1:0]          active_ff;
   logic [1:0]          active_in;
   logic                csr_write;
   csr_index_type       csr_index;

   // current request
   logic                cur_valid_ff, cur_valid_in;
   op_type              cur_op_ff, cur_op_in;
   logic [OFFSET_W-1:0] cur_offset_ff, cur_offset_in;
   logic [BYTES_W-1:0]  cur_bytes_ff, cur_bytes_in;
   logic [MAX_REGIONS-1:0] sent_ff, sent_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   op_type              rsp_op_ff, rsp_op_in;
   logic [OFFSET_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [BYTES_W-1:0]  rsp_bytes_ff, rsp_bytes_in;
   logic                rsp_last_ff, rsp_last_in;
   status_type          rsp_status_ff, rsp_status_in;

   // chunk computation
   logic [1:0]          n_active;
   logic [BYTES_W-1:0]  reg_size  [MAX_REGIONS];
   logic [VIRT_W-1:0]   virt_begin [MAX_REGIONS];
   logic [VIRT_W-1:0]   virt_end   [MAX_REGIONS];
   logic [VIRT_W-1:0]   chunk_start [MAX_REGIONS];
   logic [VIRT_W-1:0]   chunk_stop  [MAX_REGIONS];
   logic [VIRT_W-1:0]   chunk_phys  [MAX_REGIONS];
   logic [BYTES_W-1:0]  chunk_bytes [MAX_REGIONS];
   logic [OFFSET_W-1:0] chunk_addr  [MAX_REGIONS];
   logic [MAX_REGIONS-1:0] hit, pending, sel;
   logic [VIRT_W-1:0]   req_begin, req_stop;
   logic                size_mismatch, size_zero, special, beyond, sel_last;
   logic                load, req_accept;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[4:2]);

   always_comb begin
      for (int i = 0; i < MAX_REGIONS; i++) begin
         region_start_in[i] = region_start_ff[i];
         region_end_in[i]   = region_end_ff[i];
      end
      active_in = active_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_REGION0_START:  region_start_in[0] = csr_pwdata[BYTES_W-1:0];
            CSR_REGION0_END:    region_end_in[0]   = csr_pwdata[BYTES_W-1:0];
            CSR_REGION1_START:  region_start_in[1] = csr_pwdata[BYTES_W-1:0];
            CSR_REGION1_END:    region_end_in[1]   = csr_pwdata[BYTES_W-1:0];
            CSR_REGION2_START:  region_start_in[2] = csr_pwdata[BYTES_W-1:0];
            CSR_REGION2_END:    region_end_in[2]   = csr_pwdata[BYTES_W-1:0];
            CSR_ACTIVE_REGIONS: active_in          = csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_REGION0_START:  csr_prdata = CSR_DATA_W'(region_start_ff[0]);
         CSR_REGION0_END:    csr_prdata = CSR_DATA_W'(region_end_ff[0]);
         CSR_REGION1_START:  csr_prdata = CSR_DATA_W'(region_start_ff[1]);
         CSR_REGION1_END:    csr_prdata = CSR_DATA_W'(region_end_ff[1]);
         CSR_REGION2_START:  csr_prdata = CSR_DATA_W'(region_start_ff[2]);
         CSR_REGION2_END:    csr_prdata = CSR_DATA_W'(region_end_ff[2]);
         CSR_ACTIVE_REGIONS: csr_prdata = CSR_DATA_W'(active_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // region layout and chunks of the current request
   assign n_active  = (active_ff > NumRegions) ? NumRegions : active_ff;
   assign req_begin = VIRT_W'(cur_offset_ff);
   assign req_stop  = VIRT_W'(cur_offset_ff) + VIRT_W'(cur_bytes_ff);

   always_comb begin
      for (int i = 0; i < MAX_REGIONS; i++) begin
         if ((2'(i) < n_active) && (region_end_ff[i] > region_start_ff[i])) begin
            reg_size[i] = region_end_ff[i] - region_start_ff[i];
         end else begin
            reg_size[i] = '0;
         end
      end
      virt_begin[0] = '0;
      virt_end[0]   = VIRT_W'(reg_size[0]);
      for (int i = 1; i < MAX_REGIONS; i++) begin
         virt_begin[i] = virt_end[i-1];
         virt_end[i]   = virt_end[i-1] + VIRT_W'(reg_size[i]);
      end
      for (int i = 0; i < MAX_REGIONS; i++) begin
         hit[i] = (reg_size[i] != '0) && (virt_end[i] > req_begin) &&
                  (virt_begin[i] < req_stop);
         chunk_start[i] = (req_begin > virt_begin[i]) ? req_begin : virt_begin[i];
         chunk_stop[i]  = (req_stop < virt_end[i]) ? req_stop : virt_end[i];
         chunk_bytes[i] = BYTES_W'(chunk_stop[i] - chunk_start[i]);
         chunk_phys[i]  = VIRT_W'(region_start_ff[i]) + (chunk_start[i] - virt_begin[i]);
         chunk_addr[i]  = chunk_phys[i][OFFSET_W-1:0] & AddrMask;
      end
   end

   assign size_mismatch = ((cur_op_ff == OP_SECTOR_ERASE) && (cur_bytes_ff != SectorBytes)) ||
      ((cur_op_ff == OP_SUBSECTOR_ERASE) && (cur_bytes_ff != SubsectorBytes));
   assign size_zero = (cur_bytes_ff == '0);
   assign special   = size_mismatch || size_zero || (hit == '0);
   assign beyond    = req_stop > virt_end[MAX_REGIONS-1];
   assign pending   = hit & ~sent_ff;
   assign sel       = pending & (~pending + MAX_REGIONS'(1));
   assign sel_last  = ((pending & ~sel) == '0);

   // handshake
   assign load       = cur_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !cur_valid_ff || (load && (special || sel_last));
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      cur_valid_in  = cur_valid_ff;
      sent_in       = sent_ff;
      cur_op_in     = cur_op_ff;
      cur_offset_in = cur_offset_ff;
      cur_bytes_in  = cur_bytes_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_op_in     = rsp_op_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_bytes_in  = rsp_bytes_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;

      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_op_in    = cur_op_ff;
         if (special) begin
            rsp_addr_in  = '0;
            rsp_bytes_in = '0;
            rsp_last_in  = 1'b1;
            if (size_mismatch) begin
               rsp_status_in = STATUS_ERASE_SIZE;
            end else if (size_zero) begin
               rsp_status_in = STATUS_OK;
            end else begin
               rsp_status_in = STATUS_BEYOND;
            end
            cur_valid_in = 1'b0;
         end else begin
            rsp_addr_in  = '0;
            rsp_bytes_in = '0;
            for (int i = 0; i < MAX_REGIONS; i++) begin
               if (sel[i]) begin
                  rsp_addr_in  = chunk_addr[i];
                  rsp_bytes_in = chunk_bytes[i];
               end
            end
            rsp_last_in   = sel_last;
            rsp_status_in = (sel_last && beyond) ? STATUS_BEYOND : STATUS_OK;
            sent_in       = sent_ff | sel;
            if (sel_last) begin
               cur_valid_in = 1'b0;
            end
         end
      end

      if (req_accept) begin
         cur_valid_in  = 1'b1;
         sent_in       = '0;
         cur_op_in     = op_type'(req_tuser);
         cur_offset_in = req_tdata[OFFSET_W-1:0];
         cur_bytes_in  = req_tdata[OFFSET_W+BYTES_W-1:OFFSET_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_REGIONS; i++) begin
            region_start_ff[i] <= '0;
            region_end_ff[i]   <= '0;
         end
         active_ff    <= '0;
         cur_valid_ff <= 1'b0;
         sent_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < MAX_REGIONS; i++) begin
            region_start_ff[i] <= region_start_in[i];
            region_end_ff[i]   <= region_end_in[i];
         end
         active_ff    <= active_in;
         cur_valid_ff <= cur_valid_in;
         sent_ff      <= sent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_op_ff     <= cur_op_in;
      cur_offset_ff <= cur_offset_in;
      cur_bytes_ff  <= cur_bytes_in;
      rsp_op_ff     <= rsp_op_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_bytes_ff  <= rsp_bytes_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(TDATA_W-OFFSET_W-BYTES_W){1'b0}}, rsp_bytes_ff, rsp_addr_ff};
   assign rsp_tuser  = {rsp_status_ff, rsp_op_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

>>> sim/region_concat_address_splitter_checker.sv
// checker for the region concatenation address splitter: predicts and compares flash commands
module region_concat_address_splitter_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [rcas_pkg::TDATA_W-1:0]       req_tdata,
   input  logic [1:0]                         req_tuser,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [rcas_pkg::TDATA_W-1:0]       rsp_tdata,
   input  logic [3:0]                         rsp_tuser,
   input  logic                               rsp_tlast,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [rcas_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rcas_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   input  logic                               csr_pready,
   output int                                 failures,
   output int                                 pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import rcas_pkg::*;

   typedef struct {
      op_type              op;
      logic [OFFSET_W-1:0] addr;
      logic [BYTES_W-1:0]  bytes;
      logic                last;
      status_type          status;
   } flash_cmd_type;

   flash_cmd_type      expected_cmds[$];
   logic [BYTES_W-1:0] region_base [MAX_REGIONS];
   logic [BYTES_W-1:0] region_limit [MAX_REGIONS];
   logic [1:0]         active_count = '0;
   int                 fail_count = 0;
   int                 queued = 0;

   assign failures = fail_count;
   assign pending  = queued;

   task automatic report(string msg);
      $display("%0t ns  flash command mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   task automatic predict_commands(op_type op, logic [OFFSET_W-1:0] offset,
                                   logic [BYTES_W-1:0] bytes);
      logic [VIRT_W-1:0] cursor, remain, vbegin, vend, avail, span, rsize, phys;
      flash_cmd_type     pieces[$];
      flash_cmd_type     cmd;
      int                n, i;
      cmd.op     = op;
      cmd.addr   = '0;
      cmd.bytes  = '0;
      cmd.last   = 1'b1;
      cmd.status = STATUS_OK;
      if ((op == OP_SECTOR_ERASE && bytes != BYTES_W'(SECTOR_BYTES_DEF)) ||
          (op == OP_SUBSECTOR_ERASE && bytes != BYTES_W'(SUBSECTOR_BYTES_DEF))) begin
         cmd.status = STATUS_ERASE_SIZE;
         pieces.push_back(cmd);
      end else if (bytes == '0) begin
         pieces.push_back(cmd);
      end else begin
         n      = (int'(active_count) > MAX_REGIONS) ? MAX_REGIONS : int'(active_count);
         cursor = VIRT_W'(offset);
         remain = VIRT_W'(bytes);
         vbegin = '0;
         for (i = 0; i < n && remain != '0; i++) begin
            rsize = (region_limit[i] > region_base[i]) ? region_limit[i] - region_base[i] : '0;
            vend  = vbegin + rsize;
            if (cursor < vend) begin
               avail      = vend - cursor;
               span       = (avail < remain) ? avail : remain;
               phys       = region_base[i] + (cursor - vbegin);
               cmd.addr   = OFFSET_W'(phys);
               cmd.bytes  = BYTES_W'(span);
               cmd.last   = 1'b0;
               cmd.status = STATUS_OK;
               pieces.push_back(cmd);
               remain = remain - span;
               cursor = cursor + span;
            end
            vbegin = vend;
         end
         if (pieces.size() == 0) begin
            cmd.status = STATUS_BEYOND;
            pieces.push_back(cmd);
         end else begin
            pieces[pieces.size() - 1].last = 1'b1;
            if (remain != '0)
               pieces[pieces.size() - 1].status = STATUS_BEYOND;
         end
      end
      foreach (pieces[k])
         expected_cmds.push_back(pieces[k]);
   endtask

   always @(posedge clock) begin
      flash_cmd_type want;
      if (reset) begin
         foreach (region_base[i]) begin
            region_base[i]  = '0;
            region_limit[i] = '0;
         end
         active_count = '0;
         expected_cmds.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]))
               CSR_REGION0_START:  region_base[0]  = BYTES_W'(csr_pwdata);
               CSR_REGION0_END:    region_limit[0] = BYTES_W'(csr_pwdata);
               CSR_REGION1_START:  region_base[1]  = BYTES_W'(csr_pwdata);
               CSR_REGION1_END:    region_limit[1] = BYTES_W'(csr_pwdata);
               CSR_REGION2_START:  region_base[2]  = BYTES_W'(csr_pwdata);
               CSR_REGION2_END:    region_limit[2] = BYTES_W'(csr_pwdata);
               CSR_ACTIVE_REGIONS: active_count    = csr_pwdata[1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_cmds.size() == 0) begin
               report($sformatf("unexpected transaction addr %h bytes %h",
                                rsp_tdata[OFFSET_W-1:0],
                                rsp_tdata[OFFSET_W+BYTES_W-1:OFFSET_W]));
            end else begin
               want = expected_cmds.pop_front();
               if (rsp_tuser[1:0] !== want.op)
                  report($sformatf("flash_op expected %0d got %0d", want.op, rsp_tuser[1:0]));
               if (rsp_tdata[OFFSET_W-1:0] !== want.addr)
                  report($sformatf("flash_addr expected %h got %h", want.addr,
                                   rsp_tdata[OFFSET_W-1:0]));
               if (rsp_tdata[OFFSET_W+BYTES_W-1:OFFSET_W] !== want.bytes)
                  report($sformatf("chunk_bytes expected %h got %h", want.bytes,
                                   rsp_tdata[OFFSET_W+BYTES_W-1:OFFSET_W]));
               if (rsp_tlast !== want.last)
                  report($sformatf("last expected %0d got %0d", want.last, rsp_tlast));
               if (rsp_tuser[3:2] !== want.status)
                  report($sformatf("status expected %0d got %0d", want.status,
                                   rsp_tuser[3:2]));
            end
         end
         if (req_tvalid && req_tready)
            predict_commands(op_type'(req_tuser), req_tdata[OFFSET_W-1:0],
                             req_tdata[OFFSET_W+BYTES_W-1:OFFSET_W]);
      end
      queued = expected_cmds.size();
   end

endmodule

>>> sim/region_concat_address_splitter_tb.sv
// testbench top for the region concatenation address splitter: stimulus and verdict
module region_concat_address_splitter_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rcas_pkg::*;

   localparam int QUIET_LIMIT = 4000;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [TDATA_W-1:0]    req_tdata = '0;   // virt_offset, req_bytes
   logic [1:0]            req_tuser = '0;   // req_type
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [TDATA_W-1:0]    rsp_tdata;        // flash_addr, chunk_bytes
   logic [3:0]            rsp_tuser;        // flash_op, status
   logic                  rsp_tlast;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    failures;
   int                    pending;
   int                    send_idle_pct = 0;
   int                    recv_idle_pct = 0;
   int                    quiet_cycles = 0;
   int unsigned           virt_bound [MAX_REGIONS+1];

   region_concat_address_splitter uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   region_concat_address_splitter_checker cmd_check (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_pready(csr_pready),
      .failures(failures), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("** region_concat_address_splitter: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, int unsigned value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
   endtask

   task automatic set_layout(int unsigned s0, int unsigned e0, int unsigned s1,
                             int unsigned e1, int unsigned s2, int unsigned e2,
                             logic [1:0] n);
      int unsigned starts [MAX_REGIONS];
      int unsigned ends [MAX_REGIONS];
      int          i;
      wait_for_drain();
      starts = '{s0, s1, s2};
      ends   = '{e0, e1, e2};
      csr_write(CSR_REGION0_START, s0);
      csr_write(CSR_REGION0_END, e0);
      csr_write(CSR_REGION1_START, s1);
      csr_write(CSR_REGION1_END, e1);
      csr_write(CSR_REGION2_START, s2);
      csr_write(CSR_REGION2_END, e2);
      csr_write(CSR_ACTIVE_REGIONS, n);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      virt_bound[0] = 0;
      for (i = 0; i < MAX_REGIONS; i++)
         virt_bound[i+1] = virt_bound[i] +
                           ((i < n && ends[i] > starts[i]) ? ends[i] - starts[i] : 0);
   endtask

   task automatic random_layout(logic [1:0] n);
      int unsigned s [MAX_REGIONS];
      int unsigned e [MAX_REGIONS];
      int          i;
      for (i = 0; i < MAX_REGIONS; i++) begin
         s[i] = $urandom_range(0, 32'h100_0000);
         if ($urandom_range(3) == 0) begin
            e[i] = $urandom_range(0, 32'h100_0000);
         end else begin
            e[i] = s[i] + $urandom_range(1, 32'h2_0000);
            if (e[i] > 32'h100_0000)
               e[i] = 32'h100_0000;
         end
      end
      set_layout(s[0], e[0], s[1], e[1], s[2], e[2], n);
   endtask

   task automatic send_request(op_type op, logic [OFFSET_W-1:0] offset,
                               logic [BYTES_W-1:0] bytes);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(TDATA_W-OFFSET_W-BYTES_W){1'b0}}, bytes, offset};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   function automatic logic [OFFSET_W-1:0] pick_offset();
      int unsigned roll, pick;
      roll = $urandom_range(3);
      if (roll < 2)
         pick = virt_bound[$urandom_range(MAX_REGIONS)] + $urandom_range(64) - 32;
      else if (roll == 2 && virt_bound[MAX_REGIONS] != 0)
         pick = $urandom_range(virt_bound[MAX_REGIONS] - 1);
      else
         pick = $urandom;
      return pick[OFFSET_W-1:0];
   endfunction

   function automatic logic [BYTES_W-1:0] pick_size();
      int unsigned roll;
      roll = $urandom_range(19);
      if (roll < 10)
         return BYTES_W'($urandom_range(1, 256));
      else if (roll < 16)
         return BYTES_W'($urandom_range(1, 32'h10_0000));
      else if (roll < 19)
         return BYTES_W'($urandom_range(0, 32'h100_0000));
      else
         return BYTES_W'(32'h100_0000);
   endfunction

   task automatic random_request();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 10)
         send_request(OP_SECTOR_ERASE, pick_offset(), BYTES_W'(SECTOR_BYTES_DEF));
      else if (pick < 20)
         send_request(OP_SUBSECTOR_ERASE, pick_offset(), BYTES_W'(SUBSECTOR_BYTES_DEF));
      else if (pick < 24)
         send_request(pick[0] ? OP_SECTOR_ERASE : OP_SUBSECTOR_ERASE, pick_offset(),
                      pick_size());
      else if (pick < 28)
         send_request(pick[0] ? OP_WRITE : OP_READ, pick_offset(), '0);
      else
         send_request(pick[0] ? OP_WRITE : OP_READ, pick_offset(), pick_size());
   endtask

   initial begin
      int phase, k;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // nothing active after reset
      send_request(OP_READ, 24'h0, 25'h1);
      send_request(OP_WRITE, 24'h5, 25'h100);

      set_layout(32'h10_0000, 32'h18_0000, 32'h40_0000, 32'h41_0000,
                 32'hF0_0000, 32'h100_0000, 2'd3);
      send_request(OP_READ, 24'h0, 25'h1);
      send_request(OP_WRITE, 24'h7_FFF0, 25'h20);
      send_request(OP_READ, 24'h0, 25'h19_0000);
      send_request(OP_READ, 24'h7_FFF0, 25'h11_0020);
      send_request(OP_READ, 24'h19_0000, 25'h1);
      send_request(OP_READ, 24'hFF_FFFF, 25'h100_0000);
      send_request(OP_WRITE, 24'h0, 25'h100_0000);
      send_request(OP_READ, 24'h0, 25'h0);
      send_request(OP_WRITE, 24'hFF_FFFF, 25'h0);
      send_request(OP_SECTOR_ERASE, 24'h1_0000, 25'h1_0000);
      send_request(OP_SECTOR_ERASE, 24'h0, 25'h1000);
      send_request(OP_SECTOR_ERASE, 24'h0, 25'h0);
      send_request(OP_SUBSECTOR_ERASE, 24'h8_F000, 25'h1000);
      send_request(OP_SUBSECTOR_ERASE, 24'h0, 25'h1_0000);
      send_request(OP_SUBSECTOR_ERASE, 24'h18_F800, 25'h1000);
      send_request(OP_SECTOR_ERASE, 24'h19_0000, 25'h1_0000);
      send_request(OP_READ, 24'h8_FFFF, 25'h2);
      send_request(OP_WRITE, 24'h55_5555, 25'hAA_AAAA);

      // full-size first region, empty second, inverted third
      set_layout(32'h0, 32'h100_0000, 32'h100_0000, 32'h100_0000,
                 32'h80_0000, 32'h40_0000, 2'd3);
      send_request(OP_READ, 24'h0, 25'h100_0000);
      send_request(OP_WRITE, 24'hFF_FFFF, 25'h2);

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 27;
               recv_idle_pct = 85;
            end
            1: begin
               send_idle_pct = 85;
               recv_idle_pct = 27;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (k = 0; k < 5; k++) begin
            case (k)
               0: set_layout(32'h10_0000, 32'h18_0000, 32'h40_0000, 32'h41_0000,
                             32'hF0_0000, 32'h100_0000, 2'd3);
               1: set_layout(32'h0, 32'h100_0000, 32'h100_0000, 32'h100_0000,
                             32'h80_0000, 32'h40_0000, 2'd3);
               2: set_layout(32'h1000, 32'h1010, 32'hFF_FFF0, 32'h100_0000,
                             32'h200, 32'h300, 2'd3);
               3: random_layout(2'd3);
               default: random_layout(2'($urandom_range(3)));
            endcase
            repeat (25) random_request();
         end
      end

      wait_for_drain();
      repeat (10) @(posedge clock);
      if (failures == 0)
         $display("** region_concat_address_splitter: PASSED **");
      else
         $display("** region_concat_address_splitter: FAILED **");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/rcas_pkg.sv
hw/rtl/region_concat_address_splitter.sv
sim/region_concat_address_splitter_checker.sv
sim/region_concat_address_splitter_tb.sv
